// ===== rtl/hsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsp_pkg;

  // magnitude of a parsed value, times 1000, saturated
  localparam int unsigned MAG_W = 31;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  // quotient widths of the scaling stage
  localparam int unsigned Q40_W = 26;
  localparam int unsigned Q1000_W = 22;

  // x / 40 = (x >> 3) / 5 and x / 1000 = (x >> 3) / 125, by reciprocal
  localparam logic [31:0] RECIP_5 = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_5_SHIFT = 34;
  localparam logic [28:0] RECIP_125 = 29'd274877907;
  localparam int unsigned RECIP_125_SHIFT = 35;

  typedef enum logic [2:0] {
    KIND_STROKE = 3'd0,
    KIND_POINT  = 3'd1,
    KIND_PEN    = 3'd2,
    KIND_CIRCLE = 3'd3,
    KIND_EOF    = 3'd4
  } kind_e;

  // one action word from the parser to the executor
  typedef struct packed {
    logic             stroke;
    logic             pen;
    logic             circ;
    logic             set_x;
    logic             set_y;
    logic             rel;
    logic             point;
    logic             eof;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } op_t;

  // action word with its scaled quotients
  typedef struct packed {
    op_t                op;
    logic [Q40_W-1:0]   q40;
    logic [Q1000_W-1:0] q1000;
  } scaled_t;

endpackage

`default_nettype wire

// ===== rtl/hsp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsp_front #(
  parameter int unsigned MAX_VALUE_CHARS = 19
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        end_of_file_i,
  output hsp_pkg::op_t     op_o,
  output logic             push_o
);
  import hsp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_VALUE_CHARS + 1);

  localparam logic [15:0] CMD_PD = 16'h5044;
  localparam logic [15:0] CMD_PU = 16'h5055;
  localparam logic [15:0] CMD_PA = 16'h5041;
  localparam logic [15:0] CMD_PR = 16'h5052;
  localparam logic [15:0] CMD_SP = 16'h5350;
  localparam logic [15:0] CMD_CI = 16'h4349;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CASE_MASK = 8'hDF;

  typedef enum logic [1:0] {
    PH_SEEK1,
    PH_SEEK2,
    PH_PARAMS
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [7:0]       first_q, first_d;
  logic [MAG_W-1:0] acc_q, acc_d;
  logic             nochar_q, nochar_d;
  logic             neg_q, neg_d;
  logic             start_q, start_d;
  logic             dead_q, dead_d;
  logic [1:0]       stage_q, stage_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             odd_q, odd_d;
  logic             down_q, down_d;
  logic             rel_q, rel_d;
  logic             pen_q, pen_d;
  logic             circ_q, circ_d;

  logic        is_letter, is_digit, is_num;
  logic        fin, fin_end, do_cmd;
  logic [15:0] cmd;
  logic [3:0]  dig;
  logic [35:0] acc_sum;

  always_comb begin
    is_letter = (byte_in_i inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    is_digit  = (byte_in_i inside {[8'h30:8'h39]});
    is_num    = is_digit || (byte_in_i inside {CH_DOT, CH_PLUS, CH_MINUS});
    dig       = byte_in_i[3:0];
    cmd       = {first_q & CASE_MASK, byte_in_i & CASE_MASK};
    case (stage_q)
      2'd0:    acc_sum = 36'({acc_q, 3'b000}) + 36'({acc_q, 1'b0}) + 36'(dig) * 36'd1000;
      2'd1:    acc_sum = 36'(acc_q) + 36'(dig) * 36'd100;
      2'd2:    acc_sum = 36'(acc_q) + 36'(dig) * 36'd10;
      default: acc_sum = 36'(acc_q) + 36'(dig);
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    acc_d    = acc_q;
    nochar_d = nochar_q;
    neg_d    = neg_q;
    start_d  = start_q;
    dead_d   = dead_q;
    stage_d  = stage_q;
    cnt_d    = cnt_q;
    odd_d    = odd_q;
    down_d   = down_q;
    rel_d    = rel_q;
    pen_d    = pen_q;
    circ_d   = circ_q;
    fin      = 1'b0;
    fin_end  = 1'b0;
    do_cmd   = 1'b0;
    op_o     = '0;
    push_o   = 1'b0;

    if (accept_i) begin
      if (end_of_file_i) begin
        fin = (phase_q == PH_PARAMS) && !nochar_q;
      end else begin
        case (phase_q)
          PH_PARAMS: begin
            if (is_num) begin
              nochar_d = 1'b0;
              if (cnt_q < CNT_W'(MAX_VALUE_CHARS)) begin
                cnt_d = cnt_q + CNT_W'(1);
                if (!dead_q) begin
                  if (byte_in_i == CH_PLUS || byte_in_i == CH_MINUS) begin
                    if (start_q) begin
                      dead_d = 1'b1;
                    end else begin
                      start_d = 1'b1;
                      neg_d   = neg_q || (byte_in_i == CH_MINUS);
                    end
                  end else if (byte_in_i == CH_DOT) begin
                    start_d = 1'b1;
                    if (stage_q == 2'd0) begin
                      stage_d = 2'd1;
                    end else begin
                      dead_d = 1'b1;
                    end
                  end else begin
                    start_d = 1'b1;
                    acc_d = (acc_sum > 36'(MAG_MAX)) ? MAG_MAX : acc_sum[MAG_W-1:0];
                    if (stage_q == 2'd3) begin
                      dead_d = 1'b1;
                    end else if (stage_q != 2'd0) begin
                      stage_d = stage_q + 2'd1;
                    end
                  end
                end
              end
            end else if (byte_in_i == CH_SEMI) begin
              fin     = 1'b1;
              fin_end = 1'b1;
              phase_d = PH_SEEK1;
            end else if (is_letter) begin
              fin     = 1'b1;
              fin_end = 1'b1;
              first_d = byte_in_i;
              phase_d = PH_SEEK2;
            end else begin
              fin = 1'b1;
            end
          end
          PH_SEEK2: begin
            if (is_letter) begin
              do_cmd = 1'b1;
            end else begin
              phase_d = PH_SEEK1;
            end
          end
          default: begin
            if (is_letter) begin
              first_d = byte_in_i;
              phase_d = PH_SEEK2;
            end
          end
        endcase
      end

      // close the value in hand
      if (fin) begin
        op_o.pen   = pen_q;
        op_o.circ  = circ_q;
        op_o.set_x = !odd_q && !fin_end;
        op_o.set_y = odd_q;
        op_o.point = odd_q && down_q;
        op_o.rel   = rel_q;
        op_o.neg   = neg_q;
        op_o.mag   = acc_q;
        pen_d      = 1'b0;
        circ_d     = 1'b0;
        odd_d      = !odd_q;
      end

      if (do_cmd) begin
        case (cmd)
          CMD_PD: begin
            op_o.stroke = !down_q;
            down_d      = 1'b1;
          end
          CMD_PU:  down_d = 1'b0;
          CMD_PA:  rel_d = 1'b0;
          CMD_PR:  rel_d = 1'b1;
          CMD_SP:  pen_d = 1'b1;
          CMD_CI:  circ_d = 1'b1;
          default: ;
        endcase
        phase_d = PH_PARAMS;
        odd_d   = 1'b0;
      end

      if (fin || do_cmd) begin
        acc_d    = '0;
        nochar_d = 1'b1;
        neg_d    = 1'b0;
        start_d  = 1'b0;
        dead_d   = 1'b0;
        stage_d  = 2'd0;
        cnt_d    = '0;
      end

      if (end_of_file_i) begin
        op_o.eof = 1'b1;
        phase_d  = PH_SEEK1;
        first_d  = '0;
        acc_d    = '0;
        nochar_d = 1'b1;
        neg_d    = 1'b0;
        start_d  = 1'b0;
        dead_d   = 1'b0;
        stage_d  = 2'd0;
        cnt_d    = '0;
        odd_d    = 1'b0;
        down_d   = 1'b0;
        rel_d    = 1'b0;
        pen_d    = 1'b0;
        circ_d   = 1'b0;
      end

      push_o = fin || op_o.stroke || end_of_file_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEEK1;
      first_q  <= '0;
      acc_q    <= '0;
      nochar_q <= 1'b1;
      neg_q    <= 1'b0;
      start_q  <= 1'b0;
      dead_q   <= 1'b0;
      stage_q  <= 2'd0;
      cnt_q    <= '0;
      odd_q    <= 1'b0;
      down_q   <= 1'b0;
      rel_q    <= 1'b0;
      pen_q    <= 1'b0;
      circ_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      acc_q    <= acc_d;
      nochar_q <= nochar_d;
      neg_q    <= neg_d;
      start_q  <= start_d;
      dead_q   <= dead_d;
      stage_q  <= stage_d;
      cnt_q    <= cnt_d;
      odd_q    <= odd_d;
      down_q   <= down_d;
      rel_q    <= rel_d;
      pen_q    <= pen_d;
      circ_q   <= circ_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hsp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  hsp_pkg::op_t  data_i,
  output logic          full_o,
  output logic          valid_o,
  input  wire logic     pop_i,
  output hsp_pkg::op_t  data_o
);
  import hsp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  op_t              mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hsp_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsp_scale (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  hsp_pkg::op_t     q_data_i,
  output logic             q_pop_o,
  output logic             s_valid_o,
  output hsp_pkg::scaled_t s_data_o,
  input  wire logic        s_take_i
);
  import hsp_pkg::*;

  logic          s_valid_q;
  scaled_t       s_data_q;
  logic          load;
  logic [MAG_W-4:0] eighth;
  logic [59:0]   p40;
  logic [56:0]   p1000;

  assign load      = !s_valid_q || s_take_i;
  assign q_pop_o   = q_valid_i && load;
  assign s_valid_o = s_valid_q;
  assign s_data_o  = s_data_q;

  // magnitude / 8, then divide by 5 and by 125 through reciprocals
  assign eighth = q_data_i.mag[MAG_W-1:3];
  assign p40    = 60'(eighth) * 60'(RECIP_5);
  assign p1000  = 57'(eighth) * 57'(RECIP_125);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (load) begin
      s_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s_data_q.op    <= q_data_i;
      s_data_q.q40   <= p40[RECIP_5_SHIFT +: Q40_W];
      s_data_q.q1000 <= p1000[RECIP_125_SHIFT +: Q1000_W];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hsp_exec.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsp_exec (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_valid_i,
  input  hsp_pkg::scaled_t        s_data_i,
  output logic                    s_take_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic signed [31:0] cfg_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              kind_o,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      amount_o,
  output logic                    last_o
);
  import hsp_pkg::*;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  logic signed [31:0] origin_x_q, origin_y_q;
  logic signed [31:0] cur_x_q, cur_y_q;
  logic               out_valid_q;
  kind_e              kind_q;
  logic signed [31:0] pos_x_q, pos_y_q, amount_q;
  logic               last_q;
  logic               second_q;

  op_t                op;
  logic [4:0]         items, first_oh, rest, second_oh, sel_oh;
  logic               has_any, has_second, is_final, slot_free, emit;
  logic signed [31:0] amt, pen_amt, dq, base, new_val;
  logic signed [32:0] sum;
  kind_e              r_kind;
  logic signed [31:0] r_x, r_y, r_amt;

  assign op = s_data_i.op;

  // results in order: stroke, pen, circle, point, end of file
  assign items      = {op.eof, op.point, op.circ, op.pen, op.stroke};
  assign first_oh   = items & (~items + 5'd1);
  assign rest       = items & ~first_oh;
  assign second_oh  = rest & (~rest + 5'd1);
  assign has_any    = |items;
  assign has_second = |rest;
  assign sel_oh     = second_q ? second_oh : first_oh;
  assign is_final   = second_q || !has_second;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign emit       = s_valid_i && has_any && slot_free;
  assign s_take_o   = s_valid_i && (!has_any || (slot_free && is_final));

  always_comb begin
    amt     = op.neg ? -$signed({1'b0, op.mag}) : $signed({1'b0, op.mag});
    pen_amt = op.neg ? -$signed(32'(s_data_i.q1000)) : $signed(32'(s_data_i.q1000));
    dq      = op.neg ? -$signed(32'(s_data_i.q40)) : $signed(32'(s_data_i.q40));
    base    = op.set_y ? cur_y_q : cur_x_q;
    sum     = 33'(base) + 33'(dq);
    if (!op.rel) begin
      new_val = dq;
    end else if (sum[32] != sum[31]) begin
      new_val = sum[32] ? S32_MIN : S32_MAX;
    end else begin
      new_val = sum[31:0];
    end
  end

  always_comb begin
    r_kind = KIND_EOF;
    r_x    = '0;
    r_y    = '0;
    r_amt  = '0;
    if (sel_oh[0]) begin
      r_kind = KIND_STROKE;
      r_x    = cur_x_q;
      r_y    = cur_y_q;
    end else if (sel_oh[1]) begin
      r_kind = KIND_PEN;
      r_x    = cur_x_q;
      r_y    = cur_y_q;
      r_amt  = pen_amt;
    end else if (sel_oh[2]) begin
      r_kind = KIND_CIRCLE;
      r_x    = cur_x_q;
      r_y    = cur_y_q;
      r_amt  = amt;
    end else if (sel_oh[3]) begin
      r_kind = KIND_POINT;
      r_x    = cur_x_q;
      r_y    = new_val;
      r_amt  = amt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
    end else begin
      if (slot_free) begin
        out_valid_q <= emit;
      end
      if (emit) begin
        second_q <= !is_final;
      end
      if (s_take_o) begin
        if (op.eof) begin
          cur_x_q <= origin_x_q;
          cur_y_q <= origin_y_q;
        end else if (op.set_x) begin
          cur_x_q <= new_val;
        end else if (op.set_y) begin
          cur_y_q <= new_val;
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i) begin
          origin_y_q <= cfg_data_i;
          cur_y_q    <= cfg_data_i;
        end else begin
          origin_x_q <= cfg_data_i;
          cur_x_q    <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q   <= r_kind;
      pos_x_q  <= r_x;
      pos_y_q  <= r_y;
      amount_q <= r_amt;
      last_q   <= is_final;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign amount_o    = amount_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== rtl/hpgl_stream_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake              payload
// in       sink       in_valid_i/in_stall_o   byte_in_i, end_of_file_i
// out      source     out_valid_o/out_stall_i kind_o, pos_x_o, pos_y_o, amount_o, last_o
// cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one input word per cycle while in_stall_o is low; a word's results reach the output
// register through the queue, the scaling multiplier stage and the executor
// the executor sends one result word per cycle unless out_stall_i holds it, and a word
// with two results waits for both; the output port sets the sustained rate in that case
// reset is asynchronous, active low, and needs no clearing pass
// in_stall_o rises only when the action queue is full; out_stall_i holds the
// output register and backs up through the executor into the queue

module hpgl_stream_parser #(
  parameter int unsigned MAX_VALUE_CHARS = 19,
  parameter int unsigned QUEUE_DEPTH     = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         byte_in_i,
  input  wire logic               end_of_file_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              kind_o,
  output logic signed [31:0]      pos_x_o,
  output logic signed [31:0]      pos_y_o,
  output logic signed [31:0]      amount_o,
  output logic                    last_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_index_i,
  input  wire logic signed [31:0] cfg_data_i
);
  import hsp_pkg::*;

  logic    in_accept;
  logic    q_full, q_push, q_valid, q_pop;
  op_t     front_op, q_op;
  logic    s_valid, s_take;
  scaled_t s_data;

  // origin registers are always writable; the user must write only while idle, unchecked
  assign cfg_ready_o = 1'b1;

  // the front never needs more than one queue slot per word
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  // front: command letters, number characters, parameter parity and modes
  hsp_front #(
    .MAX_VALUE_CHARS(MAX_VALUE_CHARS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .byte_in_i     (byte_in_i),
    .end_of_file_i (end_of_file_i),
    .op_o          (front_op),
    .push_o        (q_push)
  );

  // short queue of action words between parser and executor
  hsp_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_op),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_op)
  );

  // divide by 40 and by 1000 ahead of the position update
  hsp_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_op),
    .q_pop_o   (q_pop),
    .s_valid_o (s_valid),
    .s_data_o  (s_data),
    .s_take_i  (s_take)
  );

  // position update, result sequencing and the output register
  hsp_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_valid),
    .s_data_i    (s_data),
    .s_take_o    (s_take),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .amount_o    (amount_o),
    .last_o      (last_o)
  );

  // end of file closes the word's results and carries no position or amount
  a_eof_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_EOF) |->
      (last_o && pos_x_o == '0 && pos_y_o == '0 && amount_o == '0))
    else $error("end of file word malformed");

  // a stroke start carries no amount
  a_stroke_amt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_STROKE) |-> (amount_o == '0))
    else $error("stroke start with non-zero amount");

  // pen number is the integer part of a saturated value
  a_pen_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_PEN) |->
      (amount_o >= -32'sd2147483 && amount_o <= 32'sd2147483))
    else $error("pen number out of range");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hsp_pkg::*;

  localparam int unsigned VALUE_CHAR_LIMIT = 19;
  localparam longint VALUE_CAP = 64'sd2147483647;
  localparam int ITEM_TARGET = 1650;
  // the last stretch of the random stream runs with no gaps and no stalls
  localparam int CALM_TAIL = 150;
  // words between origin changes in the random stream
  localparam int CFG_SPACING = 250;
  // pipeline depth plus stall bursts, so words with no result have drained
  localparam int QUIET_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic REG_ORIGIN_X = 1'b0;
  localparam logic REG_ORIGIN_Y = 1'b1;
  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    SEEK_FIRST  = 2'd0,
    SEEK_SECOND = 2'd1,
    IN_PARAMS   = 2'd2
  } parse_phase_e;

  // what ended a parameter value
  typedef enum int {
    CLOSE_EOF,
    CLOSE_SEP,
    CLOSE_END
  } close_e;

  typedef struct {
    kind_e              kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] amount;
    logic               last;
  } plot_action_t;

  // clock, reset and dut inputs, all known from time zero
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic [7:0]         byte_in_i = '0;
  logic               end_of_file_i = 1'b0;
  logic               out_stall_i = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_index_i = REG_ORIGIN_X;
  logic signed [31:0] cfg_data_i = '0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic [2:0]         kind_o;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic signed [31:0] amount_o;
  logic               last_o;
  logic               cfg_ready_o;

  hpgl_stream_parser #(
    .MAX_VALUE_CHARS(VALUE_CHAR_LIMIT)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_in_i    (byte_in_i),
    .end_of_file_i(end_of_file_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .amount_o     (amount_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------
  // parser mirror: state of the plot stream as the block should see it
  // ------------------------------------------------------------------
  parse_phase_e parse_phase;
  logic [7:0]   cmd_first;
  longint       num_mag;       // magnitude times 1000, capped
  bit           num_none;      // no character yet in this value
  bit           num_neg;
  bit           num_begun;
  bit           num_stopped;   // rest of the value is ignored
  logic [1:0]   num_stage;     // 0 integer part, 1..3 fraction digit due
  int           num_chars;
  bit           param_is_y;
  bit           pen_down;
  bit           rel_mode;
  bit           pen_due;
  bit           circle_due;
  longint       head_x;
  longint       head_y;
  longint       origin_x;
  longint       origin_y;

  plot_action_t step_out[$];
  plot_action_t actions_due[$];

  int errors = 0;
  int items_sent = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int hold_len = 0;
  int quiet_run = 0;

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return (c >= "0" && c <= "9") || c == "." || c == "+" || c == "-";
  endfunction

  function automatic longint clamp32(longint v);
    if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
    if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
    return v;
  endfunction

  function automatic void emit_action(kind_e k, longint x, longint y, longint amt);
    plot_action_t a;
    a.kind = k;
    a.x = x[31:0];
    a.y = y[31:0];
    a.amount = amt[31:0];
    a.last = 1'b0;
    step_out.push_back(a);
  endfunction

  function automatic void clear_value();
    num_mag = 0;
    num_none = 1'b1;
    num_neg = 1'b0;
    num_begun = 1'b0;
    num_stopped = 1'b0;
    num_stage = 2'd0;
    num_chars = 0;
  endfunction

  function automatic void restart_parse();
    parse_phase = SEEK_FIRST;
    cmd_first = '0;
    clear_value();
    param_is_y = 1'b0;
    pen_down = 1'b0;
    rel_mode = 1'b0;
    pen_due = 1'b0;
    circle_due = 1'b0;
    head_x = origin_x;
    head_y = origin_y;
  endfunction

  // atof-like reading: sign, digits, one point, at most three fraction digits
  function automatic void take_number_char(logic [7:0] c);
    logic [1:0] stage;
    longint     acc;
    longint     digit;
    stage = num_stage;
    num_none = 1'b0;
    if (num_chars >= VALUE_CHAR_LIMIT) return;
    num_chars++;
    if (num_stopped) return;
    if (c == "+" || c == "-") begin
      if (num_begun) begin
        num_stopped = 1'b1;
      end else begin
        num_begun = 1'b1;
        if (c == "-") num_neg = 1'b1;
      end
      return;
    end
    num_begun = 1'b1;
    if (c == ".") begin
      if (stage == 2'd0) num_stage = 2'd1;
      else num_stopped = 1'b1;
      return;
    end
    digit = c - "0";
    acc = num_mag;
    case (stage)
      2'd0: acc = acc * 10 + digit * 1000;
      2'd1: acc = acc + digit * 100;
      2'd2: acc = acc + digit * 10;
      default: acc = acc + digit;
    endcase
    num_mag = (acc > VALUE_CAP) ? VALUE_CAP : acc;
    if (stage == 2'd3) num_stopped = 1'b1;
    else if (stage != 2'd0) num_stage = stage + 2'd1;
  endfunction

  function automatic void close_value(close_e why);
    longint amt;
    amt = num_neg ? -num_mag : num_mag;
    // a pending pen or circle takes the first value, at the old position
    if (pen_due) begin
      pen_due = 1'b0;
      emit_action(KIND_PEN, head_x, head_y, amt / 1000);
    end
    if (circle_due) begin
      circle_due = 1'b0;
      emit_action(KIND_CIRCLE, head_x, head_y, amt);
    end
    if (!param_is_y) begin
      // an x ended by ';' or a letter is dropped
      if (why != CLOSE_END) head_x = rel_mode ? clamp32(head_x + amt / 40) : amt / 40;
    end else begin
      head_y = rel_mode ? clamp32(head_y + amt / 40) : amt / 40;
      if (pen_down) emit_action(KIND_POINT, head_x, head_y, amt);
    end
    param_is_y = !param_is_y;
    clear_value();
    if (why == CLOSE_END) parse_phase = SEEK_FIRST;
  endfunction

  function automatic void take_command_letter(logic [7:0] c);
    logic [7:0] a;
    logic [7:0] b;
    if (parse_phase == SEEK_SECOND) begin
      if (!is_alpha(c)) begin
        parse_phase = SEEK_FIRST;
      end else begin
        // case folding; unknown pairs still open a parameter list
        a = cmd_first & 8'hDF;
        b = c & 8'hDF;
        if (a == "P" && b == "D") begin
          if (!pen_down) emit_action(KIND_STROKE, head_x, head_y, 0);
          pen_down = 1'b1;
        end else if (a == "P" && b == "U") begin
          pen_down = 1'b0;
        end else if (a == "P" && b == "A") begin
          rel_mode = 1'b0;
        end else if (a == "P" && b == "R") begin
          rel_mode = 1'b1;
        end else if (a == "S" && b == "P") begin
          pen_due = 1'b1;
        end else if (a == "C" && b == "I") begin
          circle_due = 1'b1;
        end
        parse_phase = IN_PARAMS;
        param_is_y = 1'b0;
        clear_value();
      end
    end else if (is_alpha(c)) begin
      cmd_first = c;
      parse_phase = SEEK_SECOND;
    end
  endfunction

  // works out the result words of one accepted input word
  function automatic void predict_plot_actions(logic [7:0] c, logic eof);
    plot_action_t a;
    step_out.delete();
    if (eof) begin
      if (parse_phase == IN_PARAMS && !num_none) close_value(CLOSE_EOF);
      emit_action(KIND_EOF, 0, 0, 0);
      restart_parse();
    end else if (parse_phase == IN_PARAMS) begin
      if (is_num(c)) begin
        take_number_char(c);
      end else if (c == ";") begin
        close_value(CLOSE_END);
      end else if (is_alpha(c)) begin
        close_value(CLOSE_END);
        take_command_letter(c);
      end else begin
        close_value(CLOSE_SEP);
      end
    end else begin
      take_command_letter(c);
    end
    foreach (step_out[i]) begin
      a = step_out[i];
      a.last = (i == step_out.size() - 1);
      actions_due.push_back(a);
    end
  endfunction

  // ------------------------------------------------------------------
  // output side: stall bursts, long hold-off, result checking
  // ------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        // long hold-off so the action queue fills and input stalls
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
        out_stall_i <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    plot_action_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (actions_due.size() == 0) begin
        $display("%0t unexpected word: kind %0d, x %0d, y %0d, amount %0d", $time,
                 kind_o, pos_x_o, pos_y_o, amount_o);
        errors++;
      end else begin
        want = actions_due.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("pos_x", want.x, pos_x_o);
        check_field("pos_y", want.y, pos_y_o);
        check_field("amount", want.amount, amount_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  // watchdog: too long with no handshake on any channel
  initial begin
    while (quiet_run < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_run = 0;
      else
        quiet_run++;
    end
    $display("%0t no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // ------------------------------------------------------------------
  // input side
  // ------------------------------------------------------------------
  // offers one word and holds it until taken, then predicts its results
  task automatic send_byte(logic [7:0] c, logic eof);
    if (gaps_on && $urandom_range(0, 11) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i <= c;
    end_of_file_i <= eof;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_plot_actions(c, eof);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // sender pause until every expected word is back and the pipe is empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (actions_due.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // both origin registers, back to back; only called with the block idle
  task automatic set_origin(logic signed [31:0] ox, logic signed [31:0] oy);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_ORIGIN_X;
    cfg_data_i <= ox;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    origin_x = ox;
    head_x = ox;
    cfg_index_i <= REG_ORIGIN_Y;
    cfg_data_i <= oy;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    origin_y = oy;
    head_y = oy;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_separator();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = ",";
      1: c = " ";
      default: begin
        do c = $urandom_range(0, 255);
        while (is_alpha(c) || is_num(c) || c == ";");
      end
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return $urandom_range(0, 4000) - 2000;
      2: return $urandom;
      default: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    endcase
  endfunction

  // one decimal value: mostly short, sometimes long, empty or malformed
  task automatic send_random_value();
    int         shape;
    int         sign_pick;
    logic [7:0] digit;
    shape = $urandom_range(0, 19);
    if (shape == 0) return;
    if (shape == 1) begin
      repeat ($urandom_range(20, 28)) begin
        digit = "0" + $urandom_range(0, 9);
        send_byte(digit, 1'b0);
      end
      return;
    end
    sign_pick = $urandom_range(0, 9);
    if (sign_pick < 2) send_byte("-", 1'b0);
    else if (sign_pick == 2) send_byte("+", 1'b0);
    repeat (($urandom_range(0, 7) == 0) ? $urandom_range(4, 11) : $urandom_range(0, 3)) begin
      digit = "0" + $urandom_range(0, 9);
      send_byte(digit, 1'b0);
    end
    if ($urandom_range(0, 1)) begin
      send_byte(".", 1'b0);
      repeat ($urandom_range(0, 5)) begin
        digit = "0" + $urandom_range(0, 9);
        send_byte(digit, 1'b0);
      end
    end
    // stray sign or point after the number
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 2))
        0: send_byte("+", 1'b0);
        1: send_byte("-", 1'b0);
        default: send_byte(".", 1'b0);
      endcase
    end
  endtask

  // a command pair in random case, then its parameter list
  task automatic send_random_command();
    logic [7:0] a;
    logic [7:0] b;
    int         nparams;
    int         ending;
    case ($urandom_range(0, 7))
      0: begin a = "P"; b = "D"; end
      1: begin a = "P"; b = "U"; end
      2: begin a = "P"; b = "A"; end
      3: begin a = "P"; b = "R"; end
      4: begin a = "S"; b = "P"; end
      5: begin a = "C"; b = "I"; end
      default: begin
        a = "A" + $urandom_range(0, 25);
        b = "A" + $urandom_range(0, 25);
      end
    endcase
    if ($urandom_range(0, 1)) a = a | 8'h20;
    if ($urandom_range(0, 1)) b = b | 8'h20;
    send_byte(a, 1'b0);
    send_byte(b, 1'b0);
    nparams = $urandom_range(0, 6);
    for (int i = 0; i < nparams; i++) begin
      send_random_value();
      if (i < nparams - 1) begin
        send_byte(pick_separator(), 1'b0);
      end else begin
        // end the list with ';', with the next command letter, or a separator
        ending = $urandom_range(0, 9);
        if (ending < 6) send_byte(";", 1'b0);
        else if (ending == 9) send_byte(pick_separator(), 1'b0);
      end
    end
    if (nparams == 0 && $urandom_range(0, 1)) send_byte(";", 1'b0);
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------
  task automatic test_directed();
    set_origin(32'sd1000, -32'sd2000);
    // lower-case pen down opens a stroke; fraction digits past three dropped;
    // x ended by a letter is dropped; unknown pair then a non-letter
    send_text("pdPR+1.2345x-3;zQ");
    // sign after digits and a second point stop the number; 0xff and 0x00 as
    // separators; an empty value still moves y and plots
    send_text("PA1-2,3..4");
    send_byte(8'hFF, 1'b0);
    send_text("5");
    send_byte(8'h00, 1'b0);
    send_text(",;pu");
    // pen select takes the integer part; circle pending at end of file
    send_text("SP2.9;CI-7");
    send_byte(8'h00, 1'b1);
    // characters beyond the value length limit are ignored
    send_text("PR00000000000000000001;");
    // end of file with no character in the value drops it
    send_text("SP");
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_saturation();
    wait_idle();
    set_origin(COORD_MAX, COORD_MIN);
    send_text("PDPR800,-800;PU");
    send_byte(8'h5A, 1'b1);
    wait_idle();
    set_origin(COORD_MIN, COORD_MAX);
    send_text("PRpd-99999999999,99999999999;CI99999999999;");
    send_byte(8'hA5, 1'b1);
  endtask

  // output held off for a long stretch while points keep coming
  task automatic test_backpressure();
    wait_idle();
    set_origin('0, '0);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_len = HOLD_CYCLES;
    send_text("PDPA");
    repeat (60) send_text("7,");
    send_text(";PU");
    wait_idle();
  endtask

  task automatic test_random_stream();
    int         next_cfg;
    int         pick;
    logic [7:0] noise;
    next_cfg = items_sent;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET - CALM_TAIL) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end else if (items_sent >= next_cfg) begin
        wait_idle();
        set_origin(random_coord(), random_coord());
        next_cfg = items_sent + CFG_SPACING;
        gaps_on = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
      end
      pick = $urandom_range(0, 99);
      noise = $urandom_range(0, 255);
      if (pick < 6) send_byte(noise, 1'b0);
      else if (pick < 9) send_byte(noise, 1'b1);
      else send_random_command();
    end
  endtask

  initial begin
    origin_x = 0;
    origin_y = 0;
    restart_parse();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_directed();
    test_saturation();
    test_backpressure();
    test_random_stream();

    // drain: no more input, wait for every expected word, then a quiet spell
    in_valid_i <= 1'b0;
    while (actions_due.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
    if (errors == 0 && actions_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hsp_pkg.sv
rtl/hsp_front.sv
rtl/hsp_fifo.sv
rtl/hsp_scale.sv
rtl/hsp_exec.sv
rtl/hpgl_stream_parser.sv
tb/testbench.sv
